[rtl/core/sba_pkg.sv]
// Shared types, operation codes and a helper for the slot bitmap allocator.
package sba_pkg;

   localparam int MAX_SLOTS = 64;
   localparam int MAX_IDX_W = 6;
   localparam int DEF_SLOTS = 16;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_ADVANCE = 2'd2;
   localparam logic [1:0] OP_STATUS  = 2'd3;

   typedef struct packed {
      logic                 found;
      logic [MAX_IDX_W-1:0] idx;
   } hit_type;

   typedef struct packed {
      logic [4:0] used_count;
      logic [3:0] active_slot;
      logic       granted;
      logic [3:0] granted_slot;
   } rsp_type;

   // lowest set bit of a padded map
   function automatic hit_type lowest_set(input logic [MAX_SLOTS-1:0] v);
      hit_type h;
      h.found = 1'b0;
      h.idx   = '0;
      for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
         if (v[i]) begin
            h.found = 1'b1;
            h.idx   = MAX_IDX_W'(i);
         end
      end
      return h;
   endfunction

endpackage

[rtl/core/sba_engine.sv]
// Slot map, active pointer and used count with their update logic.
module sba_engine #(
   parameter int SLOTS = sba_pkg::DEF_SLOTS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [1:0]       op,
   input  logic [3:0]       slot_index,
   output sba_pkg::rsp_type rsp
);

   localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   logic [SLOTS-1:0] map_ff, map_in;
   logic [PW-1:0]    ptr_ff, ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   logic [SLOTS-1:0] clr, set, hi, map_free, adv_map;
   sba_pkg::hit_type free_hit, hi_hit, all_hit;
   logic             has_free, in_range, ptr_match, granted;
   logic [PW-1:0]    next_ptr;
   logic [7:0]       ptr_wide, cnt_wide;

   always_comb begin
      has_free  = |(~map_ff);
      free_hit  = sba_pkg::lowest_set(sba_pkg::MAX_SLOTS'(~map_ff));
      in_range  = 8'(slot_index) < 8'(SLOTS);
      ptr_match = 8'(slot_index) == 8'(ptr_ff);
      for (int i = 0; i < SLOTS; i++) begin
         clr[i] = 8'(i) == 8'(slot_index);
         set[i] = 8'(i) == 8'(free_hit.idx);
         hi[i]  = 8'(i) > 8'(ptr_ff);
      end
      map_free = map_ff & ~clr;
      adv_map  = (op == sba_pkg::OP_FREE) ? map_free : map_ff;
      hi_hit   = sba_pkg::lowest_set(sba_pkg::MAX_SLOTS'(adv_map & hi));
      all_hit  = sba_pkg::lowest_set(sba_pkg::MAX_SLOTS'(adv_map));
      if (hi_hit.found) begin
         next_ptr = hi_hit.idx[PW-1:0];
      end else if (all_hit.found) begin
         next_ptr = all_hit.idx[PW-1:0];
      end else begin
         next_ptr = ptr_ff;
      end

      map_in   = map_ff;
      ptr_in   = ptr_ff;
      count_in = count_ff;
      granted  = 1'b0;
      unique case (op)
         sba_pkg::OP_ALLOC: begin
            if (has_free) begin
               granted  = 1'b1;
               map_in   = map_ff | set;
               count_in = count_ff + 1'b1;
               if (count_ff == '0) begin
                  ptr_in = '0;
               end
            end
         end
         sba_pkg::OP_FREE: begin
            if (in_range) begin
               map_in   = map_free;
               count_in = count_ff - CW'(|(map_ff & clr));
               if (ptr_match) begin
                  ptr_in = next_ptr;
               end
            end
         end
         sba_pkg::OP_ADVANCE: begin
            ptr_in = next_ptr;
         end
         sba_pkg::OP_STATUS: begin
         end
         default: begin
         end
      endcase

      ptr_wide         = 8'(ptr_in);
      cnt_wide         = 8'(count_in);
      rsp.granted      = granted;
      rsp.granted_slot = granted ? free_hit.idx[3:0] : 4'd0;
      rsp.active_slot  = ptr_wide[3:0];
      rsp.used_count   = cnt_wide[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff   <= '0;
         ptr_ff   <= '0;
         count_ff <= '0;
      end else if (step) begin
         map_ff   <= map_in;
         ptr_ff   <= ptr_in;
         count_ff <= count_in;
      end
   end

   a_count_tracks_map: assert property (@(posedge clock) disable iff (reset)
      $countones(map_ff) == int'(count_ff))
      else $error("used count out of step with slot map");

   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      int'(ptr_ff) < SLOTS)
      else $error("active pointer beyond slot range");

   a_alloc_grants_when_room: assert property (@(posedge clock) disable iff (reset)
      step && op == sba_pkg::OP_ALLOC && int'(count_ff) < SLOTS |-> rsp.granted)
      else $error("allocate refused with free slots left");

   a_status_keeps_state: assert property (@(posedge clock) disable iff (reset)
      step && op == sba_pkg::OP_STATUS |=> map_ff == $past(map_ff) && ptr_ff == $past(ptr_ff))
      else $error("status operation changed state");

endmodule

[rtl/core/slot_bitmap_allocator_rr_top.sv]
// Slot bitmap allocator top level: input word register, update engine, result register.
//
// Usage:
//   Each word on the req_ channel carries one operation in req_tuser (allocate,
//   free, advance pointer, status) and a slot number in req_tdata, used by free.
//   Every accepted word yields exactly one rsp_ word with the granted slot and
//   flag, the active pointer and the used count after that operation.
//   Each accepted word is held in the input register; then the map, pointer and
//   count update and the result land in the result register together. Throughput
//   is one word per cycle while results are taken; the update path is three
//   priority encoders over the slot map, so a word can follow in the very next
//   cycle and sees the state the previous one left.
//   Reset (synchronous, active high) empties the map, sets the pointer and
//   count to zero and drops both pipeline registers; nothing is needed after.
//   When rsp_tready is low the result register holds, the input register
//   fills, and req_tready drops until the result is taken.
module slot_bitmap_allocator_rr_top #(
   parameter int SLOTS = sba_pkg::DEF_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] slot_index, [7:4] zero
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [3:0] granted_slot, [4] granted, [8:5] active_slot,
                                    // [13:9] used_count, [15:14] zero
);

   logic             in_valid_ff;
   logic [1:0]       in_op_ff;
   logic [3:0]       in_idx_ff;
   logic             out_valid_ff;
   sba_pkg::rsp_type out_ff;
   sba_pkg::rsp_type rsp_in;
   logic             move;

   assign move       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || move;

   sba_engine #(
      .SLOTS(SLOTS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .step      (move),
      .op        (in_op_ff),
      .slot_index(in_idx_ff),
      .rsp       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff  <= req_tuser;
         in_idx_ff <= req_tdata[3:0];
      end
      if (move) begin
         out_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_ff};

endmodule
